### hw/rtl/mavg_pkg.sv
// Shared types and constants for the moving average block.
// No dependencies.
`default_nettype none

package mavg_pkg;

	localparam int DATA_W     = 32;
	localparam int SUM_W      = 39;
	localparam int WL_W       = 7;
	localparam int WT_W       = 17;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT    = 4'd1;

	localparam logic [WT_W-1:0] WEIGHT_ONE = 17'd65536;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} mavg_state_t;

endpackage

`default_nettype wire

### hw/rtl/mavg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/mavg_div.sv
// Radix-2 restoring divider: signed window sum by unsigned window length,
// truncated toward zero, one quotient bit per cycle. Depends on mavg_pkg.
`default_nettype none

module mavg_div import mavg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SUM_W-1:0]  dividend,
	input  wire logic [WL_W-1:0]   divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [WL_W-1:0]  rem_q;
	logic [WL_W-1:0]  dsr_q;
	logic             neg_q;

	logic [WL_W:0]    rem_sh;
	logic [WL_W+1:0]  trial;
	logic             q_bit;
	logic [SUM_W-1:0] quo_neg;
	logic [SUM_W-1:0] dvd_abs;

	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign trial   = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign q_bit   = ~trial[WL_W+1];
	assign quo_neg = -quo_q;
	assign dvd_abs = dividend[SUM_W-1] ? -dividend : dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_abs;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? trial[WL_W-1:0] : rem_sh[WL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? quo_neg[DATA_W-1:0] : quo_q[DATA_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/moving_average_sma_ema.sv
// Simple and exponential moving average over signed Q16.16 samples.
// A sample is accepted only in idle; it then passes the update, divide and output states in order,
// and the window sum goes through the 39-step bit-serial divide before the next sample is taken.
// Reset clears the window state and sets window length 1 and weight 65536;
// the sample ring holds no defined data until written, and needs no clearing pass.
// Depends on mavg_pkg, mavg_ram and mavg_div.
`default_nettype none

module moving_average_sma_ema import mavg_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  series_start,
	input  wire logic signed [DATA_W-1:0] price,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       ready_res,
	output logic signed [DATA_W-1:0]   simple_avg,
	output logic signed [DATA_W-1:0]   exp_avg,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW     = $clog2(WINDOW_MAX);
	localparam int W_CLIP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
	localparam int CMP_W  = (AW > WL_W) ? AW + 1 : WL_W + 1;

	mavg_state_t state_q, state_d;

	logic [WL_W-1:0]   wl_q;
	logic [WT_W-1:0]   weight_q;
	logic [SUM_W-1:0]  sum_q;
	logic [WL_W-1:0]   fill_q;
	logic [AW-1:0]     slot_q;
	logic [DATA_W-1:0] last_ema_q;
	logic              out_valid_q;
	logic              go_q;

	logic [DATA_W-1:0] x_q;
	logic              ready_q;
	logic              seed_q;
	logic [DATA_W-1:0] sma_q;
	logic signed [50:0] prod_s1;

	logic [WL_W-1:0]   w_eff;
	logic              slot_over;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;
	logic              filling;
	logic [DATA_W-1:0] old_val;
	logic [SUM_W-1:0]  sum_n;
	logic [CMP_W-1:0]  slot_inc;
	logic [AW-1:0]     slot_n;
	logic signed [DATA_W:0] diff;
	logic [DATA_W-1:0] ema_c;
	logic              accept;
	logic              out_free;
	logic              div_done;
	logic [DATA_W-1:0] div_q;
	logic [CFG_DATA_W-1:0] wt_clip;

	always_comb begin
		if (wl_q == '0) begin
			w_eff = WL_W'(1);
		end else if (wl_q > WL_W'(W_CLIP)) begin
			w_eff = WL_W'(W_CLIP);
		end else begin
			w_eff = wl_q;
		end
	end

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign slot_over = CMP_W'(slot_q) >= CMP_W'(w_eff);
	assign raddr     = (series_start || slot_over) ? '0 : slot_q;

	assign filling  = fill_q < w_eff;
	assign old_val  = filling ? '0 : rdata;
	assign sum_n    = sum_q + {{(SUM_W-DATA_W){x_q[DATA_W-1]}}, x_q}
	                  - {{(SUM_W-DATA_W){old_val[DATA_W-1]}}, old_val};
	assign slot_inc = CMP_W'(slot_q) + 1'b1;
	assign slot_n   = (slot_inc == CMP_W'(w_eff)) ? '0 : slot_inc[AW-1:0];
	assign diff     = $signed({x_q[DATA_W-1], x_q}) - $signed({last_ema_q[DATA_W-1], last_ema_q});
	assign ema_c    = seed_q ? sma_q : last_ema_q + prod_s1[47:16];
	assign wt_clip  = (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;

	mavg_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(slot_q),
		.wdata(x_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	mavg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (go_q),
		.dividend(sum_q),
		.divisor (w_eff),
		.done    (div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= WL_W'(1);
			weight_q    <= WEIGHT_ONE;
			sum_q       <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			last_ema_q  <= '0;
			out_valid_q <= 1'b0;
			go_q        <= 1'b0;
		end else begin
			go_q <= (state_q == ST_UPD);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LENGTH: begin
						wl_q       <= cfg_data[WL_W-1:0];
						sum_q      <= '0;
						fill_q     <= '0;
						slot_q     <= '0;
						last_ema_q <= '0;
					end
					REG_EMA_WEIGHT: begin
						weight_q <= wt_clip;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (series_start) begin
					sum_q      <= '0;
					fill_q     <= '0;
					last_ema_q <= '0;
				end
				slot_q <= raddr;
			end else if (state_q == ST_UPD) begin
				sum_q  <= sum_n;
				slot_q <= slot_n;
				if (filling) fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				if (ready_q) last_ema_q <= ema_c;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= price;
		end
		if (state_q == ST_UPD) begin
			ready_q <= filling ? (fill_q + 1'b1 == w_eff) : 1'b1;
			seed_q  <= filling;
			prod_s1 <= 51'(diff) * $signed({1'b0, weight_q});
		end
		if (div_done) begin
			sma_q <= div_q;
		end
		if (state_q == ST_OUT && out_free) begin
			ready_res  <= ready_q;
			simple_avg <= ready_q ? sma_q : '0;
			exp_avg    <= ready_q ? ema_c : '0;
		end
	end

endmodule

`default_nettype wire
